// ===== rtl/acfp_pkg.sv =====
// Shared widths, character codes and frame kind codes for the ASCII frame parser.
`timescale 1ns / 1ps
package acfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned VALUE_W = 14;
  localparam int unsigned FRAC_W  = 24;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned KIND_W  = 2;

  localparam logic [BYTE_W-1:0] CH_ZERO = 8'd48;
  localparam logic [BYTE_W-1:0] CH_NINE = 8'd57;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'd13;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_DOT  = 8'd46;
  localparam logic [BYTE_W-1:0] CH_R    = 8'd82;
  localparam logic [BYTE_W-1:0] CH_W    = 8'd87;
  localparam logic [BYTE_W-1:0] CH_C    = 8'd67;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LIMIT = 2'd3;

  // Byte positions within a frame (count of bytes already taken).
  localparam logic [POS_W-1:0] POS_IDLE     = 4'd0;
  localparam logic [POS_W-1:0] POS_CODE     = 4'd1;
  localparam logic [POS_W-1:0] POS_SECOND   = 4'd2;
  localparam logic [POS_W-1:0] POS_THIRD    = 4'd3;
  localparam logic [POS_W-1:0] POS_VAL_LAST = 4'd5;
  localparam logic [POS_W-1:0] POS_W_CR     = 4'd6;
  localparam logic [POS_W-1:0] POS_W_LF     = 4'd7;
  localparam logic [POS_W-1:0] POS_FRAC_END = 4'd8;
  localparam logic [POS_W-1:0] POS_C_CR     = 4'd9;
  localparam logic [POS_W-1:0] POS_C_LF     = 4'd10;

  localparam logic [DIGIT_W-1:0] LIMIT_CODE = 4'd2;

endpackage

// ===== rtl/acfp_in_if.sv =====
// Byte input channel: valid/ready handshake carrying one received byte.
`timescale 1ns / 1ps
interface acfp_in_if;
  import acfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/acfp_out_if.sv =====
// Decoded frame channel: valid/ready handshake carrying one parsed command.
`timescale 1ns / 1ps
interface acfp_out_if;
  import acfp_pkg::*;

  logic               valid;
  logic               ready;
  logic               is_read;
  logic [DIGIT_W-1:0] command_code;
  logic [VALUE_W-1:0] write_value;
  logic               is_current_limit;
  logic [DIGIT_W-1:0] limit_int_digit;
  logic [FRAC_W-1:0]  limit_fraction_bcd;

  modport source (
    output valid, output is_read, output command_code, output write_value,
    output is_current_limit, output limit_int_digit, output limit_fraction_bcd,
    input ready
  );
  modport sink (
    input valid, input is_read, input command_code, input write_value,
    input is_current_limit, input limit_int_digit, input limit_fraction_bcd,
    output ready
  );
endinterface

// ===== rtl/ascii_command_frame_parser_core.sv =====
// Top level: ASCII R/W/C command frame parser with input and result registers.
`timescale 1ns / 1ps
// Takes one received byte per cycle and recognizes three frames: R d CR LF
// (read), W c dddd CR LF (write, four-digit decimal value) and C i . ffffff CR LF
// (current limit, reported with code 2). One result leaves for each complete
// frame, on its final LF; any byte that does not fit drops the frame and is
// discarded. Bytes land in an input register and are decoded in the next cycle
// against the frame state; a result is registered when its LF is decoded. The
// sustained rate is one byte per cycle: the single result register only holds
// back a byte that completes a frame while a previous result is still waiting,
// every other byte keeps flowing behind a stalled result.
module ascii_command_frame_parser_core (
  input logic            clk,
  input logic            rst_n,
  acfp_in_if.sink        in_ch,
  acfp_out_if.source     out_ch
);
  import acfp_pkg::*;

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [DIGIT_W-1:0] code_r, code_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;

  logic               emit;
  logic               advance;
  logic               is_dig;
  logic [DIGIT_W-1:0] dig;
  logic [VALUE_W-1:0] val_step;

  logic               out_valid_r;
  logic               res_read_nxt, res_lim_nxt;
  logic [DIGIT_W-1:0] res_code_nxt, res_int_nxt;
  logic [VALUE_W-1:0] res_val_nxt;
  logic [FRAC_W-1:0]  res_frac_nxt;
  logic               res_read_r, res_lim_r;
  logic [DIGIT_W-1:0] res_code_r, res_int_r;
  logic [VALUE_W-1:0] res_val_r;
  logic [FRAC_W-1:0]  res_frac_r;

  assign is_dig   = (in_byte_r >= CH_ZERO) && (in_byte_r <= CH_NINE);
  assign dig      = DIGIT_W'(in_byte_r - CH_ZERO);
  // x*10 + d as two shifted adds, wrapping at the field width
  assign val_step = VALUE_W'({val_r, 3'b000}) + VALUE_W'({val_r, 1'b0})
                    + VALUE_W'(dig);

  always_comb begin
    pos_nxt      = POS_IDLE;
    kind_nxt     = KIND_NONE;
    code_nxt     = code_r;
    val_nxt      = val_r;
    frac_nxt     = frac_r;
    emit         = 1'b0;
    res_read_nxt = 1'b0;
    res_code_nxt = code_r;
    res_val_nxt  = '0;
    res_lim_nxt  = 1'b0;
    res_int_nxt  = '0;
    res_frac_nxt = '0;
    if (pos_r == POS_IDLE) begin
      if (in_byte_r == CH_R || in_byte_r == CH_W || in_byte_r == CH_C) begin
        pos_nxt  = POS_CODE;
        kind_nxt = (in_byte_r == CH_R) ? KIND_READ :
                   (in_byte_r == CH_W) ? KIND_WRITE : KIND_LIMIT;
        code_nxt = '0;
        val_nxt  = '0;
        frac_nxt = '0;
      end
    end else begin
      case (kind_r)
        KIND_READ: begin
          if (pos_r == POS_CODE && is_dig) begin
            code_nxt = dig;
            pos_nxt  = POS_SECOND;
            kind_nxt = kind_r;
          end else if (pos_r == POS_SECOND && in_byte_r == CH_CR) begin
            pos_nxt  = POS_THIRD;
            kind_nxt = kind_r;
          end else if (pos_r == POS_THIRD && in_byte_r == CH_LF) begin
            emit         = 1'b1;
            res_read_nxt = 1'b1;
          end
        end
        KIND_WRITE: begin
          if (pos_r == POS_CODE && is_dig) begin
            code_nxt = dig;
            pos_nxt  = POS_SECOND;
            kind_nxt = kind_r;
          end else if (pos_r >= POS_SECOND && pos_r <= POS_VAL_LAST && is_dig) begin
            val_nxt  = val_step;
            pos_nxt  = pos_r + 1'b1;
            kind_nxt = kind_r;
          end else if (pos_r == POS_W_CR && in_byte_r == CH_CR) begin
            pos_nxt  = POS_W_LF;
            kind_nxt = kind_r;
          end else if (pos_r == POS_W_LF && in_byte_r == CH_LF) begin
            emit        = 1'b1;
            res_val_nxt = val_r;
          end
        end
        KIND_LIMIT: begin
          if (pos_r == POS_CODE && is_dig) begin
            code_nxt = dig;
            pos_nxt  = POS_SECOND;
            kind_nxt = kind_r;
          end else if (pos_r == POS_SECOND && in_byte_r == CH_DOT) begin
            pos_nxt  = POS_THIRD;
            kind_nxt = kind_r;
          end else if (pos_r >= POS_THIRD && pos_r <= POS_FRAC_END && is_dig) begin
            frac_nxt = {frac_r[FRAC_W-DIGIT_W-1:0], dig};
            pos_nxt  = pos_r + 1'b1;
            kind_nxt = kind_r;
          end else if (pos_r == POS_C_CR && in_byte_r == CH_CR) begin
            pos_nxt  = POS_C_LF;
            kind_nxt = kind_r;
          end else if (pos_r == POS_C_LF && in_byte_r == CH_LF) begin
            emit         = 1'b1;
            res_code_nxt = LIMIT_CODE;
            res_lim_nxt  = 1'b1;
            res_int_nxt  = code_r;
            res_frac_nxt = frac_r;
          end
        end
        default: begin
          // busy position with no frame kind: drop to idle
        end
      endcase
    end
  end

  // A byte only waits when it completes a frame and the result slot is full.
  assign advance      = in_valid_r && (!emit || !out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= POS_IDLE;
      kind_r      <= KIND_NONE;
      code_r      <= '0;
      val_r       <= '0;
      frac_r      <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        pos_r  <= pos_nxt;
        kind_r <= kind_nxt;
        code_r <= code_nxt;
        val_r  <= val_nxt;
        frac_r <= frac_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (advance && emit) begin
      res_read_r <= res_read_nxt;
      res_code_r <= res_code_nxt;
      res_val_r  <= res_val_nxt;
      res_lim_r  <= res_lim_nxt;
      res_int_r  <= res_int_nxt;
      res_frac_r <= res_frac_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.is_read            = res_read_r;
  assign out_ch.command_code       = res_code_r;
  assign out_ch.write_value        = res_val_r;
  assign out_ch.is_current_limit   = res_lim_r;
  assign out_ch.limit_int_digit    = res_int_r;
  assign out_ch.limit_fraction_bcd = res_frac_r;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_C_LF)
    else $error("frame position out of range");

  a_idle_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == KIND_NONE) |-> (pos_r == POS_IDLE))
    else $error("frame kind cleared while mid-frame");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit) |=> (pos_r == POS_IDLE && out_valid_r))
    else $error("frame completion did not return to idle with a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit) |-> (!out_valid_r || out_ch.ready))
    else $error("pending result overwritten");

  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_byte_r)))
    else $error("stalled byte lost");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the ASCII command frame parser: byte stimulus, frame prediction, result checks.
`timescale 1ns / 1ps
module tb_top;
  import acfp_pkg::*;

  typedef struct packed {
    logic               is_read;
    logic [DIGIT_W-1:0] command_code;
    logic [VALUE_W-1:0] write_value;
    logic               is_current_limit;
    logic [DIGIT_W-1:0] limit_int_digit;
    logic [FRAC_W-1:0]  limit_fraction_bcd;
  } frame_t;

  logic clk;
  logic rst_n;

  acfp_in_if  in_ch ();
  acfp_out_if out_ch ();

  ascii_command_frame_parser_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Frame tracking state, mirrors what the parser should hold
  logic [POS_W-1:0]   rx_pos;
  logic [KIND_W-1:0]  rx_kind;
  logic [DIGIT_W-1:0] code_dig;
  logic [VALUE_W-1:0] value_acc;
  logic [FRAC_W-1:0]  frac_sr;

  frame_t pending_frames[$];
  int     mismatch_count;
  int     framed_bytes;
  int     send_idle_pct;
  int     stall_pct;
  int     hold_left;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("** ascii_command_frame_parser_core: FAILED **");
    $finish;
  end

  // Works out the decoded frame, if any, that one accepted byte completes.
  task automatic predict_byte(input logic [BYTE_W-1:0] b);
    logic [DIGIT_W-1:0] d;
    logic               digit;
    logic               fit;
    frame_t             f;
    d     = DIGIT_W'(b - CH_ZERO);
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    fit   = 1'b0;
    f     = '0;
    if (rx_pos == POS_IDLE) begin
      if (b == CH_R || b == CH_W || b == CH_C) begin
        rx_kind   = (b == CH_R) ? KIND_READ : (b == CH_W) ? KIND_WRITE : KIND_LIMIT;
        rx_pos    = POS_CODE;
        code_dig  = '0;
        value_acc = '0;
        frac_sr   = '0;
      end
    end else begin
      if (rx_pos == POS_CODE && digit && rx_kind != KIND_NONE) begin
        code_dig = d;
        rx_pos   = POS_SECOND;
        fit      = 1'b1;
      end else begin
        case (rx_kind)
          KIND_READ: begin
            if (rx_pos == POS_SECOND && b == CH_CR) begin
              rx_pos = POS_THIRD;
              fit    = 1'b1;
            end else if (rx_pos == POS_THIRD && b == CH_LF) begin
              f.is_read      = 1'b1;
              f.command_code = code_dig;
              pending_frames.push_back(f);
            end
          end
          KIND_WRITE: begin
            if (rx_pos >= POS_SECOND && rx_pos <= POS_VAL_LAST && digit) begin
              value_acc = VALUE_W'(value_acc * 10 + d);
              rx_pos    = rx_pos + 1'b1;
              fit       = 1'b1;
            end else if (rx_pos == POS_W_CR && b == CH_CR) begin
              rx_pos = POS_W_LF;
              fit    = 1'b1;
            end else if (rx_pos == POS_W_LF && b == CH_LF) begin
              f.command_code = code_dig;
              f.write_value  = value_acc;
              pending_frames.push_back(f);
            end
          end
          KIND_LIMIT: begin
            if (rx_pos == POS_SECOND && b == CH_DOT) begin
              rx_pos = POS_THIRD;
              fit    = 1'b1;
            end else if (rx_pos >= POS_THIRD && rx_pos <= POS_FRAC_END && digit) begin
              frac_sr = {frac_sr[FRAC_W-DIGIT_W-1:0], d};
              rx_pos  = rx_pos + 1'b1;
              fit     = 1'b1;
            end else if (rx_pos == POS_C_CR && b == CH_CR) begin
              rx_pos = POS_C_LF;
              fit    = 1'b1;
            end else if (rx_pos == POS_C_LF && b == CH_LF) begin
              f.command_code       = LIMIT_CODE;
              f.is_current_limit   = 1'b1;
              f.limit_int_digit    = code_dig;
              f.limit_fraction_bcd = frac_sr;
              pending_frames.push_back(f);
            end
          end
          default: fit = 1'b0;
        endcase
      end
      // completed frames land here too: back to idle
      if (!fit) begin
        rx_pos  = POS_IDLE;
        rx_kind = KIND_NONE;
      end
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(BYTE_W'(s[i]));
  endtask

  function automatic logic [BYTE_W-1:0] rand_digit();
    return BYTE_W'(CH_ZERO + $urandom_range(9));
  endfunction

  // One frame with random digits; a broken one has one byte replaced and is cut after it.
  task automatic send_frame(input bit broken);
    logic [BYTE_W-1:0] seq[$];
    int                cut;
    case ($urandom_range(2))
      0: seq = {CH_R, rand_digit()};
      1: begin
        seq = {CH_W};
        repeat (5) seq.push_back(rand_digit());
      end
      default: begin
        seq = {CH_C, rand_digit(), CH_DOT};
        repeat (6) seq.push_back(rand_digit());
      end
    endcase
    seq.push_back(CH_CR);
    seq.push_back(CH_LF);
    if (broken) begin
      cut = $urandom_range(seq.size() - 1, 1);
      case ($urandom_range(3))
        0: seq[cut] = BYTE_W'($urandom_range(255));
        1: seq[cut] = CH_R;
        2: seq[cut] = CH_LF;
        default: seq[cut] = CH_DOT;
      endcase
      while (seq.size() > cut + 1) void'(seq.pop_back());
    end
    foreach (seq[i]) send_byte(seq[i]);
    framed_bytes += seq.size();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic string frame_str(input frame_t f);
    return $sformatf("read=%0d code=%0d value=%0d limit=%0d int=%0d frac=%06h",
                     f.is_read, f.command_code, f.write_value, f.is_current_limit,
                     f.limit_int_digit, f.limit_fraction_bcd);
  endfunction

  always @(posedge clk) begin : check_results
    frame_t got;
    frame_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.is_read            = out_ch.is_read;
      got.command_code       = out_ch.command_code;
      got.write_value        = out_ch.write_value;
      got.is_current_limit   = out_ch.is_current_limit;
      got.limit_int_digit    = out_ch.limit_int_digit;
      got.limit_fraction_bcd = out_ch.limit_fraction_bcd;
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected frame result: %s", frame_str(got));
      end else begin
        want = pending_frames.pop_front();
        if (got.is_read !== want.is_read || got.command_code !== want.command_code ||
            got.write_value !== want.write_value ||
            got.is_current_limit !== want.is_current_limit ||
            got.limit_int_digit !== want.limit_int_digit ||
            got.limit_fraction_bcd !== want.limit_fraction_bcd) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("frame mismatch: expected %s, got %s", frame_str(want), frame_str(got));
        end
      end
    end
  end

  // A stray byte at idle, then each frame kind at one of its digit extremes
  task automatic test_ignored_and_extremes();
    send_byte(8'hFF);
    send_text("R0\r\n");
    send_text("W99999\r\n");
    send_text("C0.000000\r\n");
  endtask

  // A bad byte drops the frame and is not taken as a new start
  task automatic test_dropped_frames();
    send_text("RW");
    send_text("R9\r\n");
    send_byte(8'h00);
  endtask

  // Long receiver hold-off while frames keep coming, so the input backs up
  task automatic test_back_pressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 300;
    repeat (25) send_frame(1'b0);
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int nbytes);
    int start;
    int pick;
    send_idle_pct = idle;
    stall_pct     = stall;
    start         = framed_bytes;
    while (framed_bytes - start < nbytes) begin
      pick = $urandom_range(99);
      if (pick < 75) send_frame(1'b0);
      else if (pick < 90) send_frame(1'b1);
      else repeat ($urandom_range(3, 1)) send_byte(BYTE_W'($urandom_range(255)));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = '0;
    out_ch.ready   = 1'b0;
    rx_pos         = POS_IDLE;
    rx_kind        = KIND_NONE;
    code_dig       = '0;
    value_acc      = '0;
    frac_sr        = '0;
    mismatch_count = 0;
    framed_bytes   = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_left      = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_ignored_and_extremes();
    test_dropped_frames();
    test_back_pressure();
    test_random_traffic(0, 0, 420);
    test_random_traffic(69, 0, 420);
    test_random_traffic(0, 69, 420);
    test_random_traffic(13, 13, 420);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_frames.size() != 0) begin
      mismatch_count += pending_frames.size();
      $display("%0d expected frames never arrived", pending_frames.size());
    end

    if (mismatch_count == 0) begin
      $display("** ascii_command_frame_parser_core: PASSED **");
    end else begin
      $display("** ascii_command_frame_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
